/* design/hrkeg_pkg.sv */
package hrkeg_pkg;

    localparam int BYTE_W   = 8;
    localparam int SCAN_W   = 6;
    localparam int SLOT_MAX = 6;
    localparam int IN_W     = BYTE_W * (SLOT_MAX + 1);
    localparam int OUT_W    = 16;

    localparam logic [BYTE_W-1:0] EMPTY_CODE    = 8'd0;
    localparam logic [BYTE_W-1:0] ROLLOVER_CODE = 8'd1;

    typedef logic [1:0] key_state_t;
    localparam key_state_t ST_RELEASED = 2'd0;
    localparam key_state_t ST_HELD     = 2'd1;
    localparam key_state_t ST_JUST     = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_slot;
        logic rd_sweep;
        logic wr_slot;
        logic wr_sweep;
        logic flush;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic skip;
        logic slot_end;
        logic slot_oor;
        logic need_down;
        logic need_up;
        logic can_emit;
        logic pend_valid;
    } status_t;

endpackage

/* design/hrkeg_ctrl.sv */
module hrkeg_ctrl #(
    parameter int KEY_COUNT  = 64,
    parameter int SLOT_COUNT = 6,
    parameter int AW         = $clog2(KEY_COUNT),
    parameter int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  hrkeg_pkg::status_t sta,
    output hrkeg_pkg::cmd_t   cmd,
    output logic [SLOT_W-1:0] slot_idx,
    output logic [AW-1:0]     key_idx,
    output logic [AW-1:0]     wb_key
);
    import hrkeg_pkg::*;

    typedef enum logic [4:0] {
        IDLE    = 5'b00001,
        SLOT_RD = 5'b00010,
        SLOT_WB = 5'b00100,
        SWEEP   = 5'b01000,
        FLUSH   = 5'b10000
    } state_t;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);
    localparam logic [AW:0]       KEY_END   = (AW+1)'(KEY_COUNT);

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [AW:0]       key_reg, key_next;
    logic              wb_valid_reg, wb_valid_next;
    logic [AW-1:0]     wb_key_reg, wb_key_next;
    logic              go;

    assign s_tready = (state_reg == IDLE);
    assign slot_idx = slot_reg;
    assign key_idx  = key_reg[AW-1:0];
    assign wb_key   = wb_key_reg;

    always_comb begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        key_next      = key_reg;
        wb_valid_next = wb_valid_reg;
        wb_key_next   = wb_key_reg;
        cmd           = '0;
        go            = 1'b1;
        case (state_reg)
            IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid && !sta.skip) begin
                    state_next = SLOT_RD;
                    slot_next  = '0;
                end
            end
            SLOT_RD: begin
                if (sta.slot_end) begin
                    state_next = SWEEP;
                end else if (sta.slot_oor) begin
                    if (slot_reg == LAST_SLOT) begin
                        state_next = SWEEP;
                    end else begin
                        slot_next = slot_reg + 1'b1;
                    end
                end else begin
                    cmd.rd_slot = 1'b1;
                    state_next  = SLOT_WB;
                end
                key_next      = '0;
                wb_valid_next = 1'b0;
            end
            SLOT_WB: begin
                go = !(sta.need_down && !sta.can_emit);
                if (go) begin
                    cmd.wr_slot = 1'b1;
                    if (slot_reg == LAST_SLOT) begin
                        state_next = SWEEP;
                    end else begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = SLOT_RD;
                    end
                end
            end
            SWEEP: begin
                // hold the read pipeline while a key-up waits for room
                go = !(wb_valid_reg && sta.need_up && !sta.can_emit);
                if (go) begin
                    cmd.wr_sweep = wb_valid_reg;
                    if (key_reg != KEY_END) begin
                        cmd.rd_sweep  = 1'b1;
                        key_next      = key_reg + 1'b1;
                        wb_valid_next = 1'b1;
                        wb_key_next   = key_reg[AW-1:0];
                    end else begin
                        wb_valid_next = 1'b0;
                        if (!wb_valid_reg) begin
                            state_next = FLUSH;
                        end
                    end
                end
            end
            FLUSH: begin
                if (!sta.pend_valid) begin
                    state_next = IDLE;
                end else if (sta.can_emit) begin
                    cmd.flush  = 1'b1;
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            slot_reg     <= '0;
            key_reg      <= '0;
            wb_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            key_reg      <= key_next;
            wb_valid_reg <= wb_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wb_key_reg <= wb_key_next;
    end

endmodule

/* design/hrkeg_dpath.sv */
module hrkeg_dpath #(
    parameter int KEY_COUNT  = 64,
    parameter int SLOT_COUNT = 6,
    parameter int AW         = $clog2(KEY_COUNT),
    parameter int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [hrkeg_pkg::IN_W-1:0]  s_tdata,
    input  hrkeg_pkg::cmd_t          cmd,
    input  logic [SLOT_W-1:0]        slot_idx,
    input  logic [AW-1:0]            key_idx,
    input  logic [AW-1:0]            wb_key,
    output hrkeg_pkg::status_t       sta,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [hrkeg_pkg::OUT_W-1:0] m_tdata,
    output logic                     m_tuser,
    output logic                     m_tlast
);
    import hrkeg_pkg::*;

    localparam logic [BYTE_W:0] KEY_LIMIT = (BYTE_W+1)'(KEY_COUNT);

    logic [BYTE_W-1:0] mods_reg;
    logic [BYTE_W-1:0] slot_key_reg [SLOT_COUNT];

    key_state_t        mem [KEY_COUNT];
    logic              vld_reg [KEY_COUNT];
    key_state_t        rdata_reg;
    logic              rvld_reg;

    logic              pend_valid_reg;
    logic              pend_rel_reg;
    logic [SCAN_W-1:0] pend_code_reg;

    logic              out_valid_reg;
    logic              out_rel_reg;
    logic [BYTE_W-1:0] out_mods_reg;
    logic [SCAN_W-1:0] out_code_reg;
    logic              out_last_reg;

    logic [BYTE_W-1:0] slot_code;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              wr_en;
    key_state_t        wr_data;
    key_state_t        eff_state;
    logic              ev;
    logic [SCAN_W-1:0] ev_code;

    assign slot_code = slot_key_reg[slot_idx];
    assign eff_state = rvld_reg ? rdata_reg : ST_RELEASED;

    assign sta.skip       = (s_tdata[2*BYTE_W-1:BYTE_W] == EMPTY_CODE) ||
                            (s_tdata[3*BYTE_W-1:2*BYTE_W] == ROLLOVER_CODE);
    assign sta.slot_end   = (slot_code == EMPTY_CODE);
    assign sta.slot_oor   = ({1'b0, slot_code} >= KEY_LIMIT);
    assign sta.need_down  = (eff_state != ST_HELD) && (eff_state != ST_JUST);
    assign sta.need_up    = (eff_state == ST_HELD);
    assign sta.can_emit   = !pend_valid_reg || !out_valid_reg || m_tready;
    assign sta.pend_valid = pend_valid_reg;

    assign rd_addr = cmd.rd_slot ? slot_code[AW-1:0] : key_idx;
    assign wr_addr = cmd.wr_slot ? slot_code[AW-1:0] : wb_key;
    assign wr_en   = cmd.wr_slot || cmd.wr_sweep;
    assign wr_data = cmd.wr_slot ? ST_JUST :
                     (eff_state == ST_JUST) ? ST_HELD : ST_RELEASED;

    assign ev      = (cmd.wr_slot && sta.need_down) || (cmd.wr_sweep && sta.need_up);
    assign ev_code = cmd.wr_slot ? SCAN_W'(slot_code) : SCAN_W'(wb_key);

    // capture the report
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mods_reg <= s_tdata[BYTE_W-1:0];
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_key_reg[i] <= s_tdata[BYTE_W*(i+1) +: BYTE_W];
            end
        end
    end

    // key state table
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_slot || cmd.rd_sweep) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_COUNT; i++) begin
                vld_reg[i] <= 1'b0;
            end
            rvld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_slot || cmd.rd_sweep) begin
                rvld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // one event waits in the pending slot until the next one shows it is not the last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else if (cmd.flush) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b1;
        end else if (ev) begin
            pend_valid_reg <= 1'b1;
            if (pend_valid_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ev) begin
            pend_rel_reg  <= cmd.wr_sweep;
            pend_code_reg <= ev_code;
        end
        if (cmd.flush || (ev && pend_valid_reg)) begin
            out_rel_reg  <= pend_rel_reg;
            out_mods_reg <= mods_reg;
            out_code_reg <= pend_code_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - BYTE_W - SCAN_W){1'b0}}, out_code_reg, out_mods_reg};
    assign m_tuser  = out_rel_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* design/hid_report_key_event_generator.sv */
// Turns keyboard boot reports into key-down and key-up transactions. Each
// accepted report (modifiers in tdata[7:0], slots key_0..key_5 in the bytes
// above) is first scanned slot by slot, with a read and a write-back for
// each present in-range slot, then every scancode's state is swept at one
// entry per cycle, while no key-up waits for room on the result side, through
// the single read port of the key state table, then the write-back is drained
// and the final event is flushed. A report with an empty first slot or a
// rollover code in the second slot is accepted and gives nothing. Each result
// carries modifiers and scancode in tdata, key-up in tuser, and tlast on the
// final event of its report. The table starts with all keys released; no
// clearing pass is needed.
module hid_report_key_event_generator #(
    parameter int KEY_COUNT  = 64,
    parameter int SLOT_COUNT = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // modifiers, key_0, key_1, key_2, key_3, key_4, key_5
    input  logic [hrkeg_pkg::IN_W-1:0]  s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // event_modifiers, scancode, zero fill
    output logic [hrkeg_pkg::OUT_W-1:0] m_tdata,
    // is_release
    output logic                        m_tuser,
    output logic                        m_tlast
);
    import hrkeg_pkg::*;

    localparam int AW     = $clog2(KEY_COUNT);
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    cmd_t              cmd;
    status_t           sta;
    logic [SLOT_W-1:0] slot_idx;
    logic [AW-1:0]     key_idx;
    logic [AW-1:0]     wb_key;

    hrkeg_ctrl #(
        .KEY_COUNT  (KEY_COUNT),
        .SLOT_COUNT (SLOT_COUNT),
        .AW         (AW),
        .SLOT_W     (SLOT_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sta      (sta),
        .cmd      (cmd),
        .slot_idx (slot_idx),
        .key_idx  (key_idx),
        .wb_key   (wb_key)
    );

    hrkeg_dpath #(
        .KEY_COUNT  (KEY_COUNT),
        .SLOT_COUNT (SLOT_COUNT),
        .AW         (AW),
        .SLOT_W     (SLOT_W)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .slot_idx (slot_idx),
        .key_idx  (key_idx),
        .wb_key   (wb_key),
        .sta      (sta),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* design/hrkeg_checker.sv */
module hrkeg_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [hrkeg_pkg::IN_W-1:0]  s_tdata,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [hrkeg_pkg::OUT_W-1:0] m_tdata,
    input logic                        m_tuser,
    input logic                        m_tlast
);
    import hrkeg_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // an ignored report leaves the block ready
    a_skip_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && ((s_tdata[15:8] == EMPTY_CODE) ||
            (s_tdata[23:16] == ROLLOVER_CODE)) |=> s_tready)
        else $error("ignored report made the block busy");

    // a processed report occupies the block
    a_work_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata[15:8] != EMPTY_CODE) &&
            (s_tdata[23:16] != ROLLOVER_CODE) |=> !s_tready)
        else $error("block ready right after taking a report");

    // while idle only the final event of a report may still wait
    a_idle_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast)
        else $error("idle with a non-final event outstanding");

endmodule

bind hid_report_key_event_generator hrkeg_checker u_hrkeg_checker (.*);

/* dv/key_event_checker.sv */
module key_event_checker #(
    parameter int KEY_COUNT  = 64,
    parameter int SLOT_COUNT = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [hrkeg_pkg::IN_W-1:0]  s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [hrkeg_pkg::OUT_W-1:0] m_tdata,
    input  logic                        m_tuser,
    input  logic                        m_tlast,
    output int                          fail_count,
    output int                          pending
);
    import hrkeg_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic              is_release;
        logic [BYTE_W-1:0] event_modifiers;
        logic [SCAN_W-1:0] scancode;
        logic              last_event;
    } key_event_t;

    key_event_t expected_events [$];
    key_state_t key_table [KEY_COUNT];

    // Scan the slots for new presses, then sweep the table for releases.
    task automatic predict_key_events(input logic [IN_W-1:0] report);
        logic [BYTE_W-1:0] mods;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] slot [SLOT_MAX];
        key_event_t        batch [$];
        key_event_t        ev;
        int                i;
        mods = report[BYTE_W-1:0];
        for (i = 0; i < SLOT_MAX; i++) begin
            slot[i] = report[BYTE_W*(i+1) +: BYTE_W];
        end
        if (slot[0] == EMPTY_CODE || slot[1] == ROLLOVER_CODE) begin
            return;
        end
        for (i = 0; i < SLOT_COUNT; i++) begin
            code = slot[i];
            if (code == EMPTY_CODE) begin
                break;
            end
            if (code < KEY_COUNT) begin
                if (key_table[code] == ST_HELD) begin
                    key_table[code] = ST_JUST;
                end else if (key_table[code] != ST_JUST) begin
                    ev.is_release      = 1'b0;
                    ev.event_modifiers = mods;
                    ev.scancode        = code[SCAN_W-1:0];
                    ev.last_event      = 1'b0;
                    batch.push_back(ev);
                    key_table[code] = ST_JUST;
                end
            end
        end
        for (i = 0; i < KEY_COUNT; i++) begin
            case (key_table[i])
                ST_HELD: begin
                    ev.is_release      = 1'b1;
                    ev.event_modifiers = mods;
                    ev.scancode        = i[SCAN_W-1:0];
                    ev.last_event      = 1'b0;
                    batch.push_back(ev);
                    key_table[i] = ST_RELEASED;
                end
                ST_JUST: begin
                    key_table[i] = ST_HELD;
                end
                default: begin
                    key_table[i] = ST_RELEASED;
                end
            endcase
        end
        if (batch.size() > 0) begin
            batch[batch.size()-1].last_event = 1'b1;
        end
        foreach (batch[k]) begin
            expected_events.push_back(batch[k]);
        end
    endtask

    task automatic check_key_event();
        key_event_t got;
        key_event_t want;
        got.is_release      = m_tuser;
        got.event_modifiers = m_tdata[BYTE_W-1:0];
        got.scancode        = m_tdata[BYTE_W +: SCAN_W];
        got.last_event      = m_tlast;
        if (expected_events.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("unexpected event: rel=%0d mods=%h code=%0d last=%0d",
                         got.is_release, got.event_modifiers, got.scancode,
                         got.last_event);
            end
            return;
        end
        want = expected_events.pop_front();
        if (got.is_release !== want.is_release
                || got.event_modifiers !== want.event_modifiers
                || got.scancode !== want.scancode
                || got.last_event !== want.last_event) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("event mismatch: expected rel=%0d mods=%h code=%0d last=%0d",
                         want.is_release, want.event_modifiers, want.scancode,
                         want.last_event);
                $display("                got      rel=%0d mods=%h code=%0d last=%0d",
                         got.is_release, got.event_modifiers, got.scancode,
                         got.last_event);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < KEY_COUNT; c++) begin
                key_table[c] = ST_RELEASED;
            end
            expected_events.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_key_event();
            end
            if (s_tvalid && s_tready) begin
                predict_key_events(s_tdata);
            end
        end
        pending = expected_events.size();
    end

endmodule

/* dv/testbench.sv */
module testbench;
    import hrkeg_pkg::*;

    localparam int KEY_COUNT    = 64;
    localparam int SLOT_COUNT   = 6;
    localparam int REPORT_COUNT = 480;
    localparam int HOLD_AFTER   = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 150;
    localparam int LIMIT        = 1_500_000;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    int                  fail_count;
    int                  pending;
    int                  sent_count  = 0;
    int                  cycle_count = 0;
    int                  burst_left  = 0;
    logic [IN_W-1:0]     last_report = '0;

    hid_report_key_event_generator #(
        .KEY_COUNT  (KEY_COUNT),
        .SLOT_COUNT (SLOT_COUNT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    key_event_checker #(
        .KEY_COUNT  (KEY_COUNT),
        .SLOT_COUNT (SLOT_COUNT)
    ) chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic logic [IN_W-1:0] pack_report(
        input logic [7:0] mods, input logic [7:0] k0, input logic [7:0] k1,
        input logic [7:0] k2, input logic [7:0] k3, input logic [7:0] k4,
        input logic [7:0] k5
    );
        return {k5, k4, k3, k2, k1, k0, mods};
    endfunction

    function automatic logic [IN_W-1:0] random_bits();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[IN_W-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] pick_code(input int slot,
                                                    input logic [BYTE_W-1:0] prev);
        int roll;
        logic [BYTE_W-1:0] code;
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
            code = BYTE_W'($urandom_range(2, 13));
        end else if (roll < 85) begin
            code = BYTE_W'($urandom_range(1, KEY_COUNT - 1));
        end else if (roll < 93) begin
            code = BYTE_W'($urandom_range(KEY_COUNT, 255));
        end else if (slot > 0 && prev != EMPTY_CODE) begin
            code = prev;
        end else begin
            code = BYTE_W'($urandom_range(2, 13));
        end
        // keep slot 1 clear of the rollover marker
        if (slot == 1 && code == ROLLOVER_CODE) begin
            code = 8'd2;
        end
        return code;
    endfunction

    // Mostly well-formed reports over a small key pool so that keys stay held
    // across reports; the rest is raw noise and empty or rollover reports.
    function automatic logic [IN_W-1:0] random_report();
        logic [BYTE_W-1:0] keys [SLOT_MAX];
        logic [IN_W-1:0]   r;
        int                roll;
        int                used;
        bit                junk_tail;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
            r = random_bits();
        end else if (roll < 16) begin
            r = random_bits();
            if ($urandom_range(0, 1)) begin
                r[BYTE_W +: BYTE_W] = EMPTY_CODE;
            end else begin
                r[2*BYTE_W +: BYTE_W] = ROLLOVER_CODE;
            end
        end else if (roll < 30) begin
            r = last_report;
            r[BYTE_W-1:0] = BYTE_W'($urandom_range(0, 255));
        end else begin
            used      = $urandom_range(1, SLOT_MAX);
            junk_tail = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < SLOT_MAX; i++) begin
                if (i < used) begin
                    keys[i] = pick_code(i, (i > 0) ? keys[i-1] : EMPTY_CODE);
                end else if (i > used && junk_tail) begin
                    keys[i] = BYTE_W'($urandom_range(1, 255));
                end else begin
                    keys[i] = EMPTY_CODE;
                end
            end
            r = pack_report(BYTE_W'($urandom_range(0, 255)), keys[0], keys[1], keys[2],
                            keys[3], keys[4], keys[5]);
        end
        if (r[BYTE_W +: BYTE_W] != EMPTY_CODE && r[2*BYTE_W +: BYTE_W] != ROLLOVER_CODE) begin
            last_report = r;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end else if (roll < 60) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 80);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_report(input logic [IN_W-1:0] report);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= random_bits();
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= report;
        sent_count++;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Result side: random stalls, quiet stretches, and one long hold-off.
    initial begin
        int   len;
        int   roll;
        logic rdy;
        bit   hold_done;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (!hold_done && sent_count >= HOLD_AFTER) begin
                rdy       = 1'b0;
                len       = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 10) begin
                    rdy = 1'b1;
                    len = $urandom_range(50, 200);
                end else if (roll < 65) begin
                    rdy = 1'b1;
                    len = $urandom_range(1, 8);
                end else if (roll < 94) begin
                    rdy = 1'b0;
                    len = $urandom_range(1, 3);
                end else begin
                    rdy = 1'b0;
                    len = $urandom_range(10, 40);
                end
            end
            @(negedge aclk);
            m_tready <= rdy;
            repeat (len - 1) @(negedge aclk);
        end
    end

    initial begin
        while (cycle_count < LIMIT) @(posedge aclk);
        $display("** hid_report_key_event_generator: FAILED **");
        $finish;
    end

    initial begin
        logic [IN_W-1:0] directed [$];
        logic [IN_W-1:0] r;
        int              useful;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;

        // empty and rollover reports, with junk in the other slots
        directed.push_back(pack_report(8'h00, 8'h00, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
        directed.push_back(pack_report(8'hFF, 8'h04, 8'h01, 8'h05, 8'h00, 8'h00, 8'h00));
        directed.push_back(pack_report(8'h81, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01));
        // press, hold, then swap to another key
        directed.push_back(pack_report(8'hFF, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        directed.push_back(pack_report(8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        directed.push_back(pack_report(8'hA5, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // all six slots at the top of the key range
        directed.push_back(pack_report(8'h00, 8'h3F, 8'h3E, 8'h3D, 8'h3C, 8'h3B, 8'h3A));
        // six new keys while six are held: the most events per report
        directed.push_back(pack_report(8'hFF, 8'h02, 8'h03, 8'h07, 8'h08, 8'h09, 8'h0A));
        // repeated codes, and a zero slot ending the list early
        directed.push_back(pack_report(8'h5A, 8'h02, 8'h02, 8'h03, 8'h03, 8'h00, 8'h09));
        // out-of-range codes skipped ahead of an in-range one
        directed.push_back(pack_report(8'h3C, 8'h40, 8'hFF, 8'h80, 8'h02, 8'h00, 8'h00));
        directed.push_back(pack_report(8'hC3, 8'hC8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        directed.push_back(pack_report(8'h00, 8'hC8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // code 1 is a normal key outside the second slot
        directed.push_back(pack_report(8'hFF, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        directed.push_back(pack_report(8'h7E, 8'h01, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h00));
        directed.push_back(pack_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        directed.push_back(pack_report(8'h00, 8'h0A, 8'h00, 8'h0B, 8'h0C, 8'h0D, 8'h0E));
        directed.push_back(pack_report(8'h55, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h0A));
        directed.push_back(pack_report(8'hAA, 8'h3F, 8'h3F, 8'h01, 8'h02, 8'h3E, 8'h40));
        directed.push_back(pack_report(8'h01, 8'h80, 8'h40, 8'h7F, 8'hFE, 8'hC0, 8'h00));

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i]) begin
            send_report(directed[i]);
        end
        useful = 0;
        while (useful < REPORT_COUNT) begin
            r = random_report();
            if (r[BYTE_W +: BYTE_W] != EMPTY_CODE && r[2*BYTE_W +: BYTE_W] != ROLLOVER_CODE) begin
                useful++;
            end
            send_report(r);
        end
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("** hid_report_key_event_generator: PASSED **");
        end else begin
            $display("** hid_report_key_event_generator: FAILED **");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/hrkeg_pkg.sv
design/hrkeg_ctrl.sv
design/hrkeg_dpath.sv
design/hid_report_key_event_generator.sv
design/hrkeg_checker.sv
dv/key_event_checker.sv
dv/testbench.sv
